### hw/rtl/unique_id_deque_top_assert.svh
`ifndef UNIQUE_ID_DEQUE_TOP_ASSERT_SVH
`define UNIQUE_ID_DEQUE_TOP_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define UDQ_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define UDQ_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) else $error(msg);

`endif

### hw/rtl/udq_pkg.sv
package udq_pkg;

  localparam int unsigned CAPACITY_DEF    = 32;
  localparam int unsigned ID_BITS_DEF     = 16;
  localparam int unsigned HANDLE_BITS_DEF = 16;
  localparam int unsigned CNT_BITS_DEF    = $clog2(CAPACITY_DEF + 1);

  localparam int unsigned CMD_BITS    = 3;
  localparam int unsigned STATUS_BITS = 2;

  typedef enum logic [CMD_BITS-1:0] {
    CMD_PUSH_BACK  = 3'd0,
    CMD_PUSH_FRONT = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_REMOVE     = 3'd4
  } cmd_e;

  typedef enum logic [STATUS_BITS-1:0] {
    ST_DONE = 2'd0,
    ST_MISS = 2'd1,
    ST_DUP  = 2'd2,
    ST_FULL = 2'd3
  } status_e;

endpackage

### hw/rtl/udq_if.sv
// Command channel
interface udq_cmd_if #(
  parameter int unsigned ID_BITS     = udq_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = udq_pkg::HANDLE_BITS_DEF
);
  logic                         valid;
  logic                         ready;
  logic [udq_pkg::CMD_BITS-1:0] command;
  logic [ID_BITS-1:0]           key_id;
  logic [HANDLE_BITS-1:0]       item_handle;

  modport source (output valid, command, key_id, item_handle, input ready);
  modport sink   (input valid, command, key_id, item_handle, output ready);
endinterface

// Response channel
interface udq_rsp_if #(
  parameter int unsigned ID_BITS     = udq_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = udq_pkg::HANDLE_BITS_DEF,
  parameter int unsigned CNT_BITS    = udq_pkg::CNT_BITS_DEF
);
  logic                            valid;
  logic                            ready;
  logic [udq_pkg::STATUS_BITS-1:0] status;
  logic [ID_BITS-1:0]              out_id;
  logic [HANDLE_BITS-1:0]          out_handle;
  logic [CNT_BITS-1:0]             entry_count;

  modport source (output valid, status, out_id, out_handle, entry_count, input ready);
  modport sink   (input valid, status, out_id, out_handle, entry_count, output ready);
endinterface

### hw/rtl/unique_id_deque_top.sv
// Channel | Dir | Fields
// cmd_i   | in  | command, key_id, item_handle
// rsp_o   | out | status, out_id, out_handle, entry_count
//
// Push and remove read and check the held entries in turn until a match.
// Remove then closes the gap, moving each later entry down one place; pops need no scan.
// One command at a time; the entry memory's single read port sets the pace.
// Reset (rst_ni, async low) empties the queue; no memory clearing is needed.
// A stalled result holds in the output register; the next item is accepted
// meanwhile and waits at its end for the register to free up.
module unique_id_deque_top #(
  parameter int unsigned CAPACITY    = udq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS     = udq_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = udq_pkg::HANDLE_BITS_DEF
) (
  input logic       clk_i,
  input logic       rst_ni,
  udq_cmd_if.sink   cmd_i,
  udq_rsp_if.source rsp_o
);
  import udq_pkg::*;

  localparam int unsigned AW = $clog2(CAPACITY);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned DW = ID_BITS + HANDLE_BITS;

  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [DW-1:0] mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [DW-1:0] mem_rdata;

  udq_ctrl #(
    .CAPACITY   (CAPACITY),
    .ID_BITS    (ID_BITS),
    .HANDLE_BITS(HANDLE_BITS),
    .AW         (AW),
    .CW         (CW)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd_i),
    .rsp_o      (rsp_o),
    .mem_we_o   (mem_we),
    .mem_waddr_o(mem_waddr),
    .mem_wdata_o(mem_wdata),
    .mem_raddr_o(mem_raddr),
    .mem_rdata_i(mem_rdata)
  );

  udq_mem #(
    .DEPTH(CAPACITY),
    .WIDTH(DW),
    .AW   (AW)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

endmodule

### hw/rtl/udq_mem.sv
module udq_mem #(
  parameter int unsigned DEPTH = udq_pkg::CAPACITY_DEF,
  parameter int unsigned WIDTH = udq_pkg::ID_BITS_DEF + udq_pkg::HANDLE_BITS_DEF,
  parameter int unsigned AW    = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### hw/rtl/udq_ctrl.sv
module udq_ctrl #(
  parameter int unsigned CAPACITY    = udq_pkg::CAPACITY_DEF,
  parameter int unsigned ID_BITS     = udq_pkg::ID_BITS_DEF,
  parameter int unsigned HANDLE_BITS = udq_pkg::HANDLE_BITS_DEF,
  parameter int unsigned AW          = $clog2(CAPACITY),
  parameter int unsigned CW          = $clog2(CAPACITY + 1)
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  udq_cmd_if.sink                        cmd_i,
  udq_rsp_if.source                      rsp_o,
  output logic                           mem_we_o,
  output logic [AW-1:0]                  mem_waddr_o,
  output logic [ID_BITS+HANDLE_BITS-1:0] mem_wdata_o,
  output logic [AW-1:0]                  mem_raddr_o,
  input  logic [ID_BITS+HANDLE_BITS-1:0] mem_rdata_i
);
  import udq_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_DISPATCH, S_SCAN_RD, S_SCAN_CK, S_TAKE_RD, S_TAKE_CK,
    S_SH_RD, S_SH_WR, S_PUSH, S_FIN
  } state_e;

  state_e                  state_q;
  logic [CMD_BITS-1:0]     cmd_q;
  logic [ID_BITS-1:0]      key_q;
  logic [HANDLE_BITS-1:0]  hnd_q;
  logic [AW-1:0]           head_q;
  logic [CW-1:0]           cnt_q;
  logic [CW-1:0]           idx_q;
  logic [STATUS_BITS-1:0]  status_q;
  logic [ID_BITS-1:0]      oid_q;
  logic [HANDLE_BITS-1:0]  ohnd_q;
  logic                    ovalid_q;
  logic [STATUS_BITS-1:0]  ostatus_q;
  logic [ID_BITS-1:0]      ooid_q;
  logic [HANDLE_BITS-1:0]  oohnd_q;
  logic [CW-1:0]           ocnt_q;
  logic [ID_BITS-1:0]      rd_id;
  logic [HANDLE_BITS-1:0]  rd_hnd;
  logic [CW-1:0]           rd_idx;
  logic                    in_acc;
  logic                    is_push;

  // Logical position to memory address, circular around head
  function automatic logic [AW-1:0] phys(input logic [AW-1:0] head,
                                         input logic [CW-1:0] i);
    logic [CW:0] s;
    s = (CW+1)'(head) + (CW+1)'(i);
    if (s >= (CW+1)'(CAPACITY)) s = s - (CW+1)'(CAPACITY);
    return s[AW-1:0];
  endfunction

  assign rd_id   = mem_rdata_i[ID_BITS+HANDLE_BITS-1:HANDLE_BITS];
  assign rd_hnd  = mem_rdata_i[HANDLE_BITS-1:0];
  assign in_acc  = cmd_i.valid && cmd_i.ready;
  assign is_push = (cmd_q == CMD_PUSH_BACK) || (cmd_q == CMD_PUSH_FRONT);

  // Read address: the shift reads one entry ahead of the one it writes
  assign rd_idx      = (state_q == S_SH_RD) ? idx_q + CW'(1) : idx_q;
  assign mem_raddr_o = phys(head_q, rd_idx);

  // Write port: new entry on push, moved entry on shift
  always_comb begin
    mem_we_o    = 1'b0;
    mem_waddr_o = phys(head_q, idx_q);
    mem_wdata_o = mem_rdata_i;
    if (state_q == S_SH_WR) begin
      mem_we_o = 1'b1;
    end else if (state_q == S_PUSH && cnt_q != CW'(CAPACITY)) begin
      mem_we_o    = 1'b1;
      mem_wdata_o = {key_q, hnd_q};
      if (cmd_q == CMD_PUSH_FRONT) begin
        mem_waddr_o = (head_q == '0) ? AW'(CAPACITY - 1) : head_q - AW'(1);
      end else begin
        mem_waddr_o = phys(head_q, cnt_q);
      end
    end
  end

  assign cmd_i.ready       = (state_q == S_IDLE);
  assign rsp_o.valid       = ovalid_q;
  assign rsp_o.status      = ostatus_q;
  assign rsp_o.out_id      = ooid_q;
  assign rsp_o.out_handle  = oohnd_q;
  assign rsp_o.entry_count = ocnt_q;

  // Command sequencer and result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= S_IDLE;
      head_q   <= '0;
      cnt_q    <= '0;
      ovalid_q <= 1'b0;
    end else begin
      // S_FIN reloads the result register itself
      if (ovalid_q && rsp_o.ready && state_q != S_FIN) ovalid_q <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (in_acc) begin
            cmd_q   <= cmd_i.command;
            key_q   <= cmd_i.key_id;
            hnd_q   <= cmd_i.item_handle;
            state_q <= S_DISPATCH;
          end
        end
        S_DISPATCH: begin
          oid_q    <= '0;
          ohnd_q   <= '0;
          status_q <= ST_MISS;
          idx_q    <= '0;
          case (cmd_q)
            CMD_PUSH_BACK, CMD_PUSH_FRONT, CMD_REMOVE: begin
              if (cnt_q != '0) state_q <= S_SCAN_RD;
              else if (is_push) state_q <= S_PUSH;
              else state_q <= S_FIN;
            end
            CMD_POP_FRONT, CMD_POP_BACK: begin
              if (cnt_q == '0) begin
                state_q <= S_FIN;
              end else begin
                idx_q   <= (cmd_q == CMD_POP_FRONT) ? '0 : cnt_q - CW'(1);
                state_q <= S_TAKE_RD;
              end
            end
            default: state_q <= S_FIN;
          endcase
        end
        S_SCAN_RD: state_q <= S_SCAN_CK;
        S_SCAN_CK: begin
          if (rd_id == key_q) begin
            if (is_push) begin
              status_q <= ST_DUP;
              state_q  <= S_FIN;
            end else begin
              oid_q    <= rd_id;
              ohnd_q   <= rd_hnd;
              status_q <= ST_DONE;
              if (idx_q + CW'(1) < cnt_q) begin
                state_q <= S_SH_RD;
              end else begin
                cnt_q   <= cnt_q - CW'(1);
                state_q <= S_FIN;
              end
            end
          end else if (idx_q + CW'(1) < cnt_q) begin
            idx_q   <= idx_q + CW'(1);
            state_q <= S_SCAN_RD;
          end else begin
            state_q <= is_push ? S_PUSH : S_FIN;
          end
        end
        S_SH_RD: state_q <= S_SH_WR;
        S_SH_WR: begin
          idx_q <= idx_q + CW'(1);
          if (idx_q + CW'(2) < cnt_q) begin
            state_q <= S_SH_RD;
          end else begin
            cnt_q   <= cnt_q - CW'(1);
            state_q <= S_FIN;
          end
        end
        S_TAKE_RD: state_q <= S_TAKE_CK;
        S_TAKE_CK: begin
          oid_q    <= rd_id;
          ohnd_q   <= rd_hnd;
          status_q <= ST_DONE;
          cnt_q    <= cnt_q - CW'(1);
          if (cmd_q == CMD_POP_FRONT) begin
            head_q <= (head_q == AW'(CAPACITY - 1)) ? '0 : head_q + AW'(1);
          end
          state_q <= S_FIN;
        end
        S_PUSH: begin
          if (cnt_q == CW'(CAPACITY)) begin
            status_q <= ST_FULL;
          end else begin
            status_q <= ST_DONE;
            cnt_q    <= cnt_q + CW'(1);
            if (cmd_q == CMD_PUSH_FRONT) begin
              head_q <= mem_waddr_o;
            end
          end
          state_q <= S_FIN;
        end
        S_FIN: begin
          if (!ovalid_q || rsp_o.ready) begin
            ovalid_q  <= 1'b1;
            ostatus_q <= status_q;
            ooid_q    <= oid_q;
            oohnd_q   <= ohnd_q;
            ocnt_q    <= cnt_q;
            state_q   <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

`include "unique_id_deque_top_assert.svh"

  `UDQ_ASSERT_IMP(a_cnt_bound, 1'b1, cnt_q <= CW'(CAPACITY), "count above capacity")
  `UDQ_ASSERT_NXT(a_acc_busy, in_acc, state_q == S_DISPATCH, "accepted item not dispatched")
  `UDQ_ASSERT_NXT(a_cnt_step, 1'b1, (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) || (cnt_q + CW'(1) == $past(cnt_q)), "count moved by more than one")
  `UDQ_ASSERT_IMP(a_we_busy, mem_we_o, state_q == S_PUSH || state_q == S_SH_WR, "stray memory write")

endmodule
